>>> design/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int RES_W          = $clog2(MAX_RESULTS) + 1;
  localparam int CLK_W          = 48;
  localparam int ID_W           = 32;
  localparam int IN_DATA_W      = 72;
  localparam int OUT_DATA_W     = 72;
  localparam logic [ID_W-1:0] BAD_ID = '1;

  // operation codes on in_tuser
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result kinds on out_tuser
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_STOP   = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  // reply status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;

  // one stored timer
  typedef struct packed {
    logic [CLK_W-1:0] deadline;
    logic [31:0]      start;
    logic [31:0]      interval;
    logic             rpt;
    logic [ID_W-1:0]  ident;
    logic [31:0]      order;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FREE, ST_ALLOC, ST_FULL, ST_BAD, ST_SCAN, ST_DECIDE, ST_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic idx_clr;
    logic idx_inc;
    logic rd;
    logic best_clr;
    logic tick_go;
    logic alloc;
    logic full_rep;
    logic bad_rep;
    logic stop_done;
    logic fire;
    logic flush;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] in_op;
    logic       in_bad;
    logic       is_stop;
    logic       idx_last;
    logic       free_hit;
    logic       rd_busy;
    logic       best_found;
    logic       held_valid;
    logic       n_last;
    logic       out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

>>> design/stt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule
`default_nettype wire

>>> design/stt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module stt_ctrl
  import stt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output      logic     in_tready,
  input  wire ctl_sts_t sts,
  output      ctl_cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch    = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.best_clr = 1'b1;
          case (sts.in_op)
            OP_START: state_nxt = ST_FREE;
            OP_STOP:  state_nxt = sts.in_bad ? ST_BAD : ST_SCAN;
            OP_TICK: begin
              cmd.tick_go = 1'b1;
              state_nxt   = ST_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      // lowest free slot, one slot a cycle
      ST_FREE: begin
        if (sts.free_hit) begin
          state_nxt = ST_ALLOC;
        end else if (sts.idx_last) begin
          state_nxt = ST_FULL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_ALLOC: begin
        if (sts.out_free) begin
          cmd.alloc = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FULL: begin
        if (sts.out_free) begin
          cmd.full_rep = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (sts.out_free) begin
          cmd.bad_rep = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      // read every slot, compare in the cycle after the read
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!sts.rd_busy) begin
          if (sts.is_stop) begin
            if (sts.out_free) begin
              cmd.stop_done = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end else if (sts.best_found) begin
            if (!sts.held_valid || sts.out_free) begin
              cmd.fire = 1'b1;
              if (sts.n_last) begin
                state_nxt = ST_FLUSH;
              end else begin
                cmd.idx_clr  = 1'b1;
                cmd.best_clr = 1'b1;
                state_nxt    = ST_SCAN;
              end
            end
          end else begin
            state_nxt = sts.held_valid ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> design/stt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module stt_dp
  import stt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]            in_tuser,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [OUT_DATA_W-1:0] out_tdata,
  output      logic [1:0]            out_tuser,
  output      logic                  out_tlast,
  input  wire ctl_cmd_t              cmd,
  output      ctl_sts_t              sts
);
  localparam int IW = $clog2(NUM_TIMERS);

  logic [NUM_TIMERS-1:0] valid_r, fired_r;
  logic [IW-1:0]         idx_r, rd_idx_r, best_idx_r;
  logic                  rd_v_r;
  logic [CLK_W-1:0]      clock_r;
  logic [ID_W-1:0]       next_id_r, new_id;
  logic [31:0]           seq_r;
  logic [1:0]            op_r;
  logic [31:0]           ival_r;
  logic                  rpt_r;
  logic [ID_W-1:0]       sid_r;
  logic [RES_W-1:0]      n_r;

  logic                  best_found_r, best_rpt_r;
  logic [CLK_W-1:0]      best_dl_r;
  logic [31:0]           best_age_r, best_start_r, best_ival_r;
  logic [ID_W-1:0]       best_id_r;

  logic                  held_v_r;
  logic [ID_W-1:0]       held_id_r;
  logic [31:0]           held_el_r;

  logic                  out_v_r, out_last_r;
  logic [1:0]            out_kind_r, out_st_r;
  logic [ID_W-1:0]       out_id_r;
  logic [31:0]           out_el_r;

  slot_t                 rd_q, wr_d;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [31:0]           cand_age;
  logic                  elig, better, out_free;

  // slot store
  stt_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_TIMERS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_d),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (rd_q)
  );

  assign new_id   = ((next_id_r + 1'b1) == BAD_ID) ? ID_W'(1) : next_id_r + 1'b1;
  assign out_free = !out_v_r || out_tready;

  // write data for a new timer or a rescheduled one
  always_comb begin
    wr_en   = cmd.alloc || (cmd.fire && best_rpt_r);
    wr_addr = cmd.alloc ? idx_r : best_idx_r;
    if (cmd.alloc) begin
      wr_d.deadline = clock_r + CLK_W'(ival_r);
      wr_d.interval = ival_r;
      wr_d.rpt      = rpt_r;
      wr_d.ident    = new_id;
    end else begin
      wr_d.deadline = clock_r + CLK_W'(best_ival_r);
      wr_d.interval = best_ival_r;
      wr_d.rpt      = best_rpt_r;
      wr_d.ident    = best_id_r;
    end
    wr_d.start = clock_r[31:0];
    wr_d.order = seq_r;
  end

  // candidate check on the slot just read
  always_comb begin
    cand_age = seq_r - rd_q.order;
    if (op_r == OP_STOP) begin
      elig = valid_r[rd_idx_r] && (rd_q.ident == sid_r);
    end else begin
      elig = valid_r[rd_idx_r] && !fired_r[rd_idx_r] && (rd_q.deadline <= clock_r);
    end
    better = !best_found_r || (rd_q.deadline < best_dl_r) ||
             ((rd_q.deadline == best_dl_r) && (cand_age > best_age_r));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      fired_r   <= '0;
      rd_v_r    <= 1'b0;
      clock_r   <= '0;
      next_id_r <= '0;
      seq_r     <= '0;
      n_r       <= '0;
      held_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd;
      if (cmd.tick_go) begin
        clock_r  <= clock_r + 1'b1;
        fired_r  <= '0;
        n_r      <= '0;
        held_v_r <= 1'b0;
      end
      if (cmd.best_clr) begin
        best_found_r <= 1'b0;
      end else if (rd_v_r && elig && better) begin
        best_found_r <= 1'b1;
      end
      if (cmd.alloc) begin
        valid_r[idx_r] <= 1'b1;
        next_id_r      <= new_id;
        seq_r          <= seq_r + 1'b1;
      end
      if (cmd.stop_done && best_found_r) begin
        valid_r[best_idx_r] <= 1'b0;
      end
      if (cmd.fire) begin
        fired_r[best_idx_r] <= 1'b1;
        n_r                 <= n_r + 1'b1;
        held_v_r            <= 1'b1;
        if (best_rpt_r) begin
          seq_r <= seq_r + 1'b1;
        end else begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end
      if (cmd.flush) begin
        held_v_r <= 1'b0;
      end
      // output register
      if (cmd.alloc || cmd.full_rep || cmd.bad_rep || cmd.stop_done || cmd.flush ||
          (cmd.fire && held_v_r)) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_tuser;
      ival_r <= in_tdata[31:0];
      rpt_r  <= in_tdata[32];
      sid_r  <= in_tdata[64:33];
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    rd_idx_r <= idx_r;
    if (rd_v_r && elig && better && !cmd.best_clr) begin
      best_idx_r   <= rd_idx_r;
      best_dl_r    <= rd_q.deadline;
      best_age_r   <= cand_age;
      best_start_r <= rd_q.start;
      best_ival_r  <= rd_q.interval;
      best_rpt_r   <= rd_q.rpt;
      best_id_r    <= rd_q.ident;
    end
    if (cmd.fire) begin
      held_id_r <= best_id_r;
      held_el_r <= clock_r[31:0] - best_start_r;
    end
    // result beat contents
    if (cmd.alloc) begin
      out_kind_r <= KIND_START;
      out_id_r   <= new_id;
      out_el_r   <= '0;
      out_st_r   <= STS_OK;
      out_last_r <= 1'b1;
    end else if (cmd.full_rep) begin
      out_kind_r <= KIND_START;
      out_id_r   <= BAD_ID;
      out_el_r   <= '0;
      out_st_r   <= STS_FULL;
      out_last_r <= 1'b1;
    end else if (cmd.bad_rep || cmd.stop_done) begin
      out_kind_r <= KIND_STOP;
      out_id_r   <= sid_r;
      out_el_r   <= '0;
      out_st_r   <= cmd.bad_rep ? STS_INVALID : STS_OK;
      out_last_r <= 1'b1;
    end else if (cmd.flush || (cmd.fire && held_v_r)) begin
      out_kind_r <= KIND_EXPIRY;
      out_id_r   <= held_id_r;
      out_el_r   <= held_el_r;
      out_st_r   <= STS_OK;
      out_last_r <= cmd.flush;
    end
  end

  // status to the controller
  always_comb begin
    sts.in_op      = in_tuser;
    sts.in_bad     = (in_tdata[64:33] == BAD_ID);
    sts.is_stop    = (op_r == OP_STOP);
    sts.idx_last   = (idx_r == IW'(NUM_TIMERS - 1));
    sts.free_hit   = !valid_r[idx_r];
    sts.rd_busy    = rd_v_r;
    sts.best_found = best_found_r;
    sts.held_valid = held_v_r;
    sts.n_last     = (n_r == RES_W'(MAX_RESULTS - 1));
    sts.out_free   = out_free;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_st_r, out_el_r, out_id_r};
endmodule
`default_nettype wire

>>> design/software_timer_table.sv
// start: a one-slot-a-cycle search for the lowest free slot
// stop: one pass over the slot memory read port plus the compare, or a direct reply for the bad id
// tick: one memory pass per expiry, and a last pass that finds none unless the result limit is hit
// one item at a time; the result register frees the output side from the work, but a stall holds the item
// reset: synchronous active-low rst_n clears clock, ids, valid bits and handshakes
`timescale 1ns / 1ps
`default_nettype none
module software_timer_table
  import stt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // interval, repeat_req, timer_id
  input  wire logic [1:0]            in_tuser,   // operation
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [OUT_DATA_W-1:0] out_tdata,  // timer_id_res, elapsed_ms, status
  output      logic [1:0]            out_tuser,  // kind
  output      logic                  out_tlast
);
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stt_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );
endmodule
`default_nettype wire

>>> design/stt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module stt_checker
  import stt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]            out_tuser,
  input wire logic                  out_tlast
);
  // result beat holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped while stalled");

  // replies are single beats
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_START || out_tuser == KIND_STOP) |-> out_tlast)
    else $error("reply without last");

  // expiries carry ok status
  a_exp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_EXPIRY |-> out_tdata[65:64] == STS_OK)
    else $error("expiry with nonzero status");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat after reset");
endmodule

bind software_timer_table stt_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
